>>> rtl/irra_pkg.sv
// ----------------------------------------------------------------------------
// irra_pkg
// Shared types, breakpoint tables and helpers for the IR range reader.
// ----------------------------------------------------------------------------
`default_nettype none

package irra_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int CH_W      = 3;
  localparam int DIST_W    = 10;
  localparam int FILT_W    = 18;
  localparam int WEIGHT_W  = 17;
  localparam int DIV_N_W   = 18;
  localparam int RECIP_W   = 29;
  localparam int DIV_SHIFT = 28;
  localparam int NDIFF_W   = 9;

  // 2^DIV_SHIFT; a ceiling reciprocal at this scale is exact for any
  // dividend below 2^18 and divisor below 1024
  localparam longint unsigned RECIP_ONE = 64'd1 << DIV_SHIFT;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd19661;

  localparam logic [SAMPLE_W-1:0] CODE_HIGH = 12'd1500;
  localparam logic [SAMPLE_W-1:0] CODE_LOW  = 12'd90;
  localparam logic [DIST_W-1:0]   DIST_NEAR = 10'd200;
  localparam logic [DIST_W-1:0]   DIST_FAR  = 10'd1000;

  localparam logic [SAMPLE_W-1:0] BP_CODE [9] = '{
    12'd1500, 12'd1120, 12'd860, 12'd700, 12'd500, 12'd380, 12'd250, 12'd160, 12'd90
  };

  // per segment: 2*D*den + den, with D the far end distance
  localparam logic [DIV_N_W-1:0] SEG_BASE [8] = '{
    18'd228380, 18'd208260, 18'd160160, 18'd240200,
    18'd168120, 18'd208130, 18'd162090, 18'd140070
  };

  // per segment: ceil(2^DIV_SHIFT / (2*den))
  localparam logic [RECIP_W-1:0] SEG_RECIP [8] = '{
    RECIP_W'((RECIP_ONE + 64'd759) / 64'd760),
    RECIP_W'((RECIP_ONE + 64'd519) / 64'd520),
    RECIP_W'((RECIP_ONE + 64'd319) / 64'd320),
    RECIP_W'((RECIP_ONE + 64'd399) / 64'd400),
    RECIP_W'((RECIP_ONE + 64'd239) / 64'd240),
    RECIP_W'((RECIP_ONE + 64'd259) / 64'd260),
    RECIP_W'((RECIP_ONE + 64'd179) / 64'd180),
    RECIP_W'((RECIP_ONE + 64'd139) / 64'd140)
  };

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [RECIP_W-1:0] recip;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quo;
  } div_rsp_t;

  // segment for a code strictly inside the table range
  function automatic logic [2:0] seg_index(input logic [SAMPLE_W-1:0] code);
    logic [2:0] cnt;
    cnt = 3'd0;
    for (int j = 1; j < 8; j++) begin
      if (code < BP_CODE[j]) begin
        cnt = cnt + 3'd1;
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

>>> rtl/irra_div.sv
// ----------------------------------------------------------------------------
// irra_div
// Shared constant divider: multiply by a ceiling reciprocal, then shift.
// ----------------------------------------------------------------------------
`default_nettype none

module irra_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire irra_pkg::div_req_t req,
  output irra_pkg::div_rsp_t      rsp
);

  localparam int N_W = irra_pkg::DIV_N_W;
  localparam int R_W = irra_pkg::RECIP_W;
  localparam int P_W = N_W + irra_pkg::DIV_SHIFT;

  logic           v;
  logic           done;
  logic [N_W-1:0] num;
  logic [R_W-1:0] recip;
  logic [P_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= 1'b0;
      done <= 1'b0;
    end else begin
      v    <= req.start;
      done <= v;
    end
  end

  // the quotient stays below 2^N_W, so the product fits P_W bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      num   <= req.num;
      recip <= req.recip;
    end
    if (v) begin
      prod <= P_W'(num) * P_W'(recip);
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = prod[P_W-1 -: N_W];

endmodule

`default_nettype wire

>>> rtl/irra_ema.sv
// ----------------------------------------------------------------------------
// irra_ema
// EMA update: prev + round(w * (cur*2^8 - prev) / 2^16), three registered steps.
// ----------------------------------------------------------------------------
`default_nettype none

module irra_ema (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [irra_pkg::WEIGHT_W-1:0]     weight,
  input  wire logic [irra_pkg::DIST_W-1:0]       cur,
  input  wire logic [irra_pkg::FILT_W-1:0]       prev,
  output logic                                   done,
  output logic [irra_pkg::FILT_W-1:0]            result
);

  localparam int F_W = irra_pkg::FILT_W;
  localparam int W_W = irra_pkg::WEIGHT_W;
  localparam int P_W = W_W + F_W + 2;

  logic               v1;
  logic               v2;
  logic signed [F_W:0]   diff;
  logic [F_W-1:0]        base;
  logic [W_W-1:0]        w;
  logic signed [P_W-1:0] prod;
  logic signed [P_W-1:0] rnd;
  logic signed [F_W+1:0] sum;

  assign rnd = (prod + P_W'(32768)) >>> 16;
  assign sum = $signed({2'b00, base}) + rnd[F_W+1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      diff <= $signed({1'b0, cur, 8'b0}) - $signed({1'b0, prev});
      base <= prev;
      w    <= weight;
    end
    if (v1) begin
      prod <= P_W'($signed({1'b0, w}) * diff);
    end
    if (v2) begin
      result <= sum[F_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ir_range_average_interp_ema.sv
// ----------------------------------------------------------------------------
// ir_range_average_interp_ema
// Per-channel IR range reader: sample averaging, table interpolation, EMA.
// ----------------------------------------------------------------------------
// Input beats (channel, sample) use in_valid / in_stall. A beat for a channel
// at or above CHANNELS is dropped. Each other beat adds to its channel's sum;
// a beat that does not finish a reading leaves in_stall low, so the block
// takes the next beat without waiting. The beat that completes
// SAMPLES_PER_READING samples starts the reading: the shared reciprocal
// multiplier takes the average, the segment is found, and for a code inside
// the table the numerator is built and the multiplier runs again for the
// interpolation; the three-step EMA unit then updates the channel's filter.
// in_stall stays high until the result beat reaches the output register.
// The result is held in an output register under out_stall; while it is
// stalled a further finished result waits inside with in_stall high.
// cfg_wen / cfg_wdata write the EMA weight (Q16, saturated at one); they are
// to be used only while idle, which the block itself does not enforce.
// Synchronous rst clears all sums, counts and filter values to zero and sets
// the weight to 19661.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_range_average_interp_ema #(
  parameter int CHANNELS            = 5,
  parameter int SAMPLES_PER_READING = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wen,
  input  wire logic [irra_pkg::WEIGHT_W-1:0]     cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [irra_pkg::CH_W-1:0]         channel,
  input  wire logic [irra_pkg::SAMPLE_W-1:0]     sample,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [irra_pkg::CH_W-1:0]              out_channel,
  output logic [irra_pkg::SAMPLE_W-1:0]          average_code,
  output logic [irra_pkg::DIST_W-1:0]            raw_distance,
  output logic [irra_pkg::FILT_W-1:0]            smoothed_distance
);

  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W   = (IDX_W > irra_pkg::CH_W) ? IDX_W : irra_pkg::CH_W;
  localparam int SUM_W   = irra_pkg::SAMPLE_W + $clog2(SAMPLES_PER_READING);
  localparam int CNT_W   = $clog2(SAMPLES_PER_READING + 1);
  localparam int N_W     = irra_pkg::DIV_N_W;

  localparam longint unsigned AVG_RECIP =
    (irra_pkg::RECIP_ONE + longint'(SAMPLES_PER_READING) - 64'd1) /
    longint'(SAMPLES_PER_READING);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AVG  = 3'd1;
  localparam logic [2:0] S_SEG  = 3'd2;
  localparam logic [2:0] S_NUM  = 3'd3;
  localparam logic [2:0] S_INT  = 3'd4;
  localparam logic [2:0] S_EMA  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;

  logic [SUM_W-1:0]              sum_r  [CHANNELS];
  logic [CNT_W-1:0]              cnt_r  [CHANNELS];
  logic [irra_pkg::FILT_W-1:0]   filt_r [CHANNELS];
  logic [irra_pkg::WEIGHT_W-1:0] weight;

  logic [irra_pkg::CH_W-1:0]     ch_r;
  logic [irra_pkg::SAMPLE_W-1:0] avg_r;
  logic [irra_pkg::DIST_W-1:0]   raw_r;
  logic [2:0]                    seg_r;
  logic [irra_pkg::NDIFF_W-1:0]  n_r;

  logic [EXT_W-1:0] in_ext;
  logic [IDX_W-1:0] in_idx;
  logic [EXT_W-1:0] cur_ext;
  logic [IDX_W-1:0] cur_idx;
  logic             in_ok;
  logic             in_acc;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new;
  logic             complete;
  logic             out_free;
  logic [2:0]       seg_c;
  logic [irra_pkg::SAMPLE_W-1:0] n_full;

  irra_pkg::div_req_t div_req;
  irra_pkg::div_rsp_t div_rsp;

  logic                        ema_start;
  logic                        ema_done;
  logic [irra_pkg::DIST_W-1:0] ema_cur;
  logic [irra_pkg::FILT_W-1:0] ema_res;

  assign in_ext   = EXT_W'(channel);
  assign in_idx   = in_ext[IDX_W-1:0];
  assign cur_ext  = EXT_W'(ch_r);
  assign cur_idx  = cur_ext[IDX_W-1:0];
  assign in_ok    = (int'(channel) < CHANNELS);
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign sum_new  = sum_r[in_idx] + SUM_W'(sample);
  assign cnt_new  = cnt_r[in_idx] + CNT_W'(1);
  assign complete = (cnt_new == CNT_W'(SAMPLES_PER_READING));
  assign out_free = !out_valid || !out_stall;
  assign seg_c    = irra_pkg::seg_index(avg_r);
  assign n_full   = avg_r - irra_pkg::BP_CODE[4'(seg_c) + 4'd1];

  always_comb begin
    div_req = '0;
    if (state == S_IDLE && in_acc && in_ok && complete) begin
      div_req.start = 1'b1;
      div_req.num   = N_W'(sum_new);
      div_req.recip = irra_pkg::RECIP_W'(AVG_RECIP);
    end else if (state == S_NUM) begin
      div_req.start = 1'b1;
      div_req.num   = irra_pkg::SEG_BASE[seg_r] - N_W'(n_r) * N_W'(200);
      div_req.recip = irra_pkg::SEG_RECIP[seg_r];
    end
  end

  irra_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign ema_start = ((state == S_SEG) && ((avg_r >= irra_pkg::CODE_HIGH) ||
                      (avg_r <= irra_pkg::CODE_LOW))) ||
                     ((state == S_INT) && div_rsp.done);

  always_comb begin
    if (state == S_INT) begin
      ema_cur = div_rsp.quo[irra_pkg::DIST_W-1:0];
    end else if (avg_r >= irra_pkg::CODE_HIGH) begin
      ema_cur = irra_pkg::DIST_NEAR;
    end else begin
      ema_cur = irra_pkg::DIST_FAR;
    end
  end

  irra_ema u_ema (
    .clk    (clk),
    .rst    (rst),
    .start  (ema_start),
    .weight (weight),
    .cur    (ema_cur),
    .prev   (filt_r[cur_idx]),
    .done   (ema_done),
    .result (ema_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      weight    <= irra_pkg::WEIGHT_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]  <= '0;
        cnt_r[i]  <= '0;
        filt_r[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        weight <= (cfg_wdata > irra_pkg::WEIGHT_ONE) ? irra_pkg::WEIGHT_ONE : cfg_wdata;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && in_ok) begin
            if (complete) begin
              sum_r[in_idx] <= '0;
              cnt_r[in_idx] <= '0;
              state         <= S_AVG;
            end else begin
              sum_r[in_idx] <= sum_new;
              cnt_r[in_idx] <= cnt_new;
            end
          end
        end
        S_AVG: begin
          if (div_rsp.done) begin
            state <= S_SEG;
          end
        end
        S_SEG: begin
          if (ema_start) begin
            state <= S_EMA;
          end else begin
            state <= S_NUM;
          end
        end
        S_NUM: begin
          state <= S_INT;
        end
        S_INT: begin
          if (div_rsp.done) begin
            state <= S_EMA;
          end
        end
        S_EMA: begin
          if (ema_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            filt_r[cur_idx] <= ema_res;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      ch_r <= channel;
    end
    if (state == S_AVG && div_rsp.done) begin
      avg_r <= div_rsp.quo[irra_pkg::SAMPLE_W-1:0];
    end
    if (state == S_SEG) begin
      seg_r <= seg_c;
      n_r   <= n_full[irra_pkg::NDIFF_W-1:0];
      if (avg_r >= irra_pkg::CODE_HIGH) begin
        raw_r <= irra_pkg::DIST_NEAR;
      end else if (avg_r <= irra_pkg::CODE_LOW) begin
        raw_r <= irra_pkg::DIST_FAR;
      end
    end
    if (state == S_INT && div_rsp.done) begin
      raw_r <= div_rsp.quo[irra_pkg::DIST_W-1:0];
    end
    if (state == S_OUT && out_free) begin
      out_channel       <= ch_r;
      average_code      <= avg_r;
      raw_distance      <= raw_r;
      smoothed_distance <= ema_res;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_ir_range_average_interp_ema.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_range_average_interp_ema
// Self-checking testbench for the per-channel IR range reader.
// ----------------------------------------------------------------------------
// Sample beats go in under valid/stall with random gaps. A local predictor
// keeps per-channel sums, counts and filter state. For every beat that
// completes a reading it queues the expected average, table distance and
// EMA value. Each result beat is checked field by field against the oldest
// queued reading. Phases cover the table ends and breakpoints, half-up
// rounding, dropped channels, weight settings including zero, one and
// saturation, a long receiver hold that fills the block, and a closing
// stretch with no idling.
// ----------------------------------------------------------------------------

module tb_ir_range_average_interp_ema;

  localparam int NUM_CH        = 5;
  localparam int PER_READING   = 5;
  localparam int SETTLE_CYCLES = 80;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int unsigned UNITY_WEIGHT = 65536;
  localparam int unsigned RESET_WEIGHT = 19661;

  localparam int unsigned BREAK_CODE [9] = '{1500, 1120, 860, 700, 500, 380, 250, 160, 90};

  typedef struct packed {
    logic [irra_pkg::CH_W-1:0]     ch;
    logic [irra_pkg::SAMPLE_W-1:0] avg;
    logic [irra_pkg::DIST_W-1:0]   distance;
    logic [irra_pkg::FILT_W-1:0]   smooth;
  } reading_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_wen;
  logic [irra_pkg::WEIGHT_W-1:0]   cfg_wdata;
  logic                            in_valid;
  logic                            in_stall;
  logic [irra_pkg::CH_W-1:0]       channel;
  logic [irra_pkg::SAMPLE_W-1:0]   sample;
  logic                            out_valid;
  logic                            out_stall;
  logic [irra_pkg::CH_W-1:0]       out_channel;
  logic [irra_pkg::SAMPLE_W-1:0]   average_code;
  logic [irra_pkg::DIST_W-1:0]     raw_distance;
  logic [irra_pkg::FILT_W-1:0]     smoothed_distance;

  // predictor state
  int unsigned ema_weight;
  int unsigned ch_sum    [NUM_CH];
  int unsigned ch_count  [NUM_CH];
  int unsigned ch_filter [NUM_CH];
  reading_t    pending_readings[$];

  // stimulus shaping
  int unsigned aim_code [NUM_CH];
  bit          tx_idle_en;
  bit          rx_idle_en;
  int          rx_hold_left;

  int          err_count;
  int          readings_checked;
  int          beats_sent;
  int          beats_dropped;
  int          weights_written;
  int          cycle_count;

  ir_range_average_interp_ema DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_wen           (cfg_wen),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .channel           (channel),
    .sample            (sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel       (out_channel),
    .average_code      (average_code),
    .raw_distance      (raw_distance),
    .smoothed_distance (smoothed_distance)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("%0t: timeout, %0d readings still pending", $time, pending_readings.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned code_to_hundredths(input int unsigned code);
    int unsigned n;
    int unsigned span;
    int unsigned far_dist;
    if (code >= BREAK_CODE[0]) return 200;
    if (code <= BREAK_CODE[8]) return 1000;
    for (int i = 0; i < 8; i++) begin
      if (code <= BREAK_CODE[i] && code >= BREAK_CODE[i+1]) begin
        n        = code - BREAK_CODE[i+1];
        span     = BREAK_CODE[i] - BREAK_CODE[i+1];
        far_dist = 300 + 100 * i;
        // far_dist - 100*n/span, rounded half-up
        return (2 * far_dist * span + span - 200 * n) / (2 * span);
      end
    end
    return 1000;
  endfunction

  task automatic accumulate_sample(input int unsigned ch, input int unsigned smp);
    reading_t          r;
    int unsigned       avg;
    int unsigned       hund;
    longint unsigned   acc;
    if (ch >= NUM_CH) begin
      beats_dropped++;
      return;
    end
    ch_sum[ch]   += smp;
    ch_count[ch] += 1;
    if (ch_count[ch] < PER_READING) return;
    avg          = ch_sum[ch] / PER_READING;
    ch_sum[ch]   = 0;
    ch_count[ch] = 0;
    hund = code_to_hundredths(avg);
    acc  = longint'(ema_weight) * (longint'(hund) << 8)
         + longint'(UNITY_WEIGHT - ema_weight) * longint'(ch_filter[ch])
         + 64'd32768;
    ch_filter[ch] = int'((acc >> 16) & 64'h3FFFF);
    r.ch       = ch[irra_pkg::CH_W-1:0];
    r.avg      = avg[irra_pkg::SAMPLE_W-1:0];
    r.distance = hund[irra_pkg::DIST_W-1:0];
    r.smooth   = ch_filter[ch][irra_pkg::FILT_W-1:0];
    pending_readings.push_back(r);
  endtask

  // ---------------------------------------------------------------- drivers

  // entered and left at a falling edge; valid stays up for a back-to-back beat
  task automatic send_beat(input int unsigned ch, input int unsigned smp);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    channel  = ch[irra_pkg::CH_W-1:0];
    sample   = smp[irra_pkg::SAMPLE_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accumulate_sample(ch, smp);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_weight(input int unsigned value);
    cfg_wen   = 1'b1;
    cfg_wdata = value[irra_pkg::WEIGHT_W-1:0];
    @(negedge clk);
    cfg_wen   = 1'b0;
    ema_weight = (value > UNITY_WEIGHT) ? UNITY_WEIGHT : value;
    weights_written++;
  endtask

  function automatic int unsigned pick_aim();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return BREAK_CODE[$urandom_range(0, 8)] + $urandom_range(0, 6) - 3;
    if (sel < 9) return $urandom_range(0, 1700);
    return $urandom_range(0, 4095);
  endfunction

  // mostly coherent readings around a target code, some noise and bad channels
  task automatic send_random_beats(input int count);
    int unsigned ch;
    int unsigned smp;
    int          v;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        ch  = $urandom_range(NUM_CH, 7);
        smp = $urandom_range(0, 4095);
      end else begin
        ch = $urandom_range(0, NUM_CH - 1);
        if (ch_count[ch] == 0) aim_code[ch] = pick_aim();
        if ($urandom_range(0, 7) == 0) begin
          smp = $urandom_range(0, 4095);
        end else if ($urandom_range(0, 1) == 0) begin
          smp = aim_code[ch];
        end else begin
          v   = int'(aim_code[ch]) + $urandom_range(0, 8) - 4;
          smp = (v < 0) ? 0 : (v > 4095) ? 4095 : v;
        end
      end
      send_beat(ch, smp);
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    int burst_left;
    burst_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_stall = 1'b1;
        rx_hold_left--;
      end else if (burst_left > 0) begin
        out_stall = 1'b1;
        burst_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall  = 1'b1;
        burst_left = $urandom_range(1, 6) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading ch=%0d avg=%0d dist=%0d smooth=%0d", $time,
                 out_channel, average_code, raw_distance, smoothed_distance);
        err_count++;
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (out_channel !== want.ch) begin
          $display("%0t: out_channel expected %0d got %0d", $time, want.ch, out_channel);
          err_count++;
        end
        if (average_code !== want.avg) begin
          $display("%0t: average_code expected %0d got %0d", $time, want.avg, average_code);
          err_count++;
        end
        if (raw_distance !== want.distance) begin
          $display("%0t: raw_distance expected %0d got %0d", $time, want.distance,
                   raw_distance);
          err_count++;
        end
        if (smoothed_distance !== want.smooth) begin
          $display("%0t: smoothed_distance expected %0d got %0d", $time, want.smooth,
                   smoothed_distance);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    // dropped channels
    send_beat(5, 4095);
    send_beat(6, 12'hAAA);
    send_beat(7, 12'h555);
    // far above the table, clamps near
    repeat (5) send_beat(0, 4095);
    // zero code, clamps far
    repeat (5) send_beat(4, 0);
    // truncating average lands on the top breakpoint
    repeat (4) send_beat(1, 1500);
    send_beat(1, 1504);
    // bottom breakpoint
    repeat (4) send_beat(2, 90);
    send_beat(2, 94);
    // exact half in the 860..700 segment rounds up
    repeat (4) send_beat(3, 704);
    send_beat(3, 708);
    drain();
  endtask

  task automatic test_weights();
    int unsigned settings [5] = '{0, UNITY_WEIGHT, 131071, 1, 32768};
    foreach (settings[i]) begin
      write_weight(settings[i]);
      send_random_beats(30);
      drain();
    end
  endtask

  task automatic test_backpressure();
    rx_hold_left = 300;
    for (int k = 0; k < 30; k++) send_beat(k % 2, $urandom_range(0, 1600));
    // sender waits for every reading before resuming
    drain();
    send_random_beats(10);
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      write_weight($urandom_range(0, 131071));
      send_random_beats(60);
      drain();
    end
  endtask

  task automatic test_steady_flow();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_weight(RESET_WEIGHT);
    send_random_beats(50);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_wen      = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    channel      = '0;
    sample       = '0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    rx_hold_left = 0;
    err_count        = 0;
    readings_checked = 0;
    beats_sent       = 0;
    beats_dropped    = 0;
    weights_written  = 0;
    cycle_count      = 0;
    ema_weight = RESET_WEIGHT;
    for (int c = 0; c < NUM_CH; c++) begin
      ch_sum[c]    = 0;
      ch_count[c]  = 0;
      ch_filter[c] = 0;
      aim_code[c]  = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_weights();
    test_backpressure();
    test_random();
    test_steady_flow();
    drain();

    $display("Sent %0d sample beats (%0d on unused channels), checked %0d readings,",
             beats_sent, beats_dropped, readings_checked);
    $display("across %0d weight settings, a long output hold and a no-idle stretch.",
             weights_written + 1);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/irra_pkg.sv
rtl/irra_div.sv
rtl/irra_ema.sv
rtl/ir_range_average_interp_ema.sv
tb/tb_ir_range_average_interp_ema.sv
